[rtl/mmm_pkg.sv]
`default_nettype none
package mmm_pkg;

	localparam int LIMBS     = 4;
	localparam int MAX_LIMBS = 6;
	localparam int LIMB_W    = 64;
	localparam int HALF_W    = LIMB_W / 2;
	localparam int IDX_W     = (LIMBS > 1) ? $clog2(LIMBS) : 1;
	localparam int CNT_W     = $clog2(LIMBS + 1);
	localparam int ACC_W     = 2 * LIMB_W + 2;
	localparam int CARRY_W   = ACC_W - LIMB_W;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_M_PRIME = CFG_IDX_W'(MAX_LIMBS);

	typedef logic [LIMB_W-1:0] limb_t;

	typedef struct packed {
		logic       clear;
		logic       load_we;
		logic       cfg_we;
		logic       mac_en;
		logic       mac_init;
		logic [2:0] mac_step;
		logic       ripple_en;
		logic       shift_en;
		logic       sub_en;
	} cell_ctrl_t;

	typedef struct packed {
		logic       en;
		logic [2:0] step;
	} u_ctrl_t;

endpackage
`default_nettype wire

[rtl/mmm_in_if.sv]
`default_nettype none
interface mmm_in_if import mmm_pkg::*; ();
	logic  valid;
	logic  ready;
	limb_t x_limb;
	limb_t y_limb;
	logic  last_limb;

	modport source (output valid, output x_limb, output y_limb, output last_limb, input ready);
	modport sink (input valid, input x_limb, input y_limb, input last_limb, output ready);
endinterface
`default_nettype wire

[rtl/mmm_out_if.sv]
`default_nettype none
interface mmm_out_if import mmm_pkg::*; ();
	logic  valid;
	logic  ready;
	limb_t result_limb;
	logic  last_result;

	modport source (output valid, output result_limb, output last_result, input ready);
	modport sink (input valid, input result_limb, input last_result, output ready);
endinterface
`default_nettype wire

[rtl/mmm_cell.sv]
`default_nettype none
module mmm_cell import mmm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cell_ctrl_t         ctrl,
	input  wire limb_t              x_in,
	input  wire limb_t              y_in,
	input  wire limb_t              cfg_data,
	input  wire limb_t              xb,
	input  wire limb_t              u,
	input  wire logic [CARRY_W-1:0] carry_in,
	input  wire logic               borrow_in,
	input  wire limb_t              t_next,
	input  wire limb_t              d_next,
	output logic [CARRY_W-1:0]      carry_out,
	output logic                    borrow_out,
	output limb_t                   x_out,
	output limb_t                   y_out,
	output limb_t                   t_out,
	output limb_t                   d_out
);

	limb_t              x_q, y_q, m_q, t_q, d_q;
	logic [ACC_W-1:0]   p_q;
	logic [CARRY_W-1:0] carry_q;
	logic               borrow_q;

	limb_t              a_op, b_op;
	logic [HALF_W-1:0]  a_half, b_half;
	logic [LIMB_W-1:0]  prod;
	logic [1:0]         sh;
	logic [ACC_W-1:0]   term, p_base, w;
	logic [LIMB_W:0]    diff;

	always_comb begin
		a_op   = ctrl.mac_step[2] ? u : xb;
		b_op   = ctrl.mac_step[2] ? m_q : y_q;
		a_half = ctrl.mac_step[0] ? a_op[LIMB_W-1:HALF_W] : a_op[HALF_W-1:0];
		b_half = ctrl.mac_step[1] ? b_op[LIMB_W-1:HALF_W] : b_op[HALF_W-1:0];
		prod   = a_half * b_half;
		sh     = {1'b0, ctrl.mac_step[0]} + {1'b0, ctrl.mac_step[1]};
		term   = ACC_W'(prod) << {sh, 5'b0};
		p_base = ctrl.mac_init ? ACC_W'(t_q) : p_q;
		w      = p_q + ACC_W'(carry_in);
		diff   = {1'b0, t_q} - {1'b0, m_q} - (LIMB_W+1)'(borrow_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_q <= '0;
		else if (ctrl.cfg_we)
			m_q <= cfg_data;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_we) begin
			x_q <= x_in;
			y_q <= y_in;
		end
		if (ctrl.mac_en)
			p_q <= p_base + term;
		if (ctrl.clear)
			t_q <= '0;
		else if (ctrl.ripple_en)
			t_q <= w[LIMB_W-1:0];
		else if (ctrl.shift_en)
			t_q <= t_next;
		if (ctrl.ripple_en)
			carry_q <= w[ACC_W-1:LIMB_W];
		if (ctrl.sub_en) begin
			d_q      <= diff[LIMB_W-1:0];
			borrow_q <= diff[LIMB_W];
		end else if (ctrl.shift_en)
			d_q <= d_next;
	end

	assign carry_out  = carry_q;
	assign borrow_out = borrow_q;
	assign x_out      = x_q;
	assign y_out      = y_q;
	assign t_out      = t_q;
	assign d_out      = d_q;

endmodule
`default_nettype wire

[rtl/mmm_u_unit.sv]
`default_nettype none
module mmm_u_unit import mmm_pkg::*; (
	input  wire logic    clk,
	input  wire u_ctrl_t ctrl,
	input  wire limb_t   xb,
	input  wire limb_t   y0,
	input  wire limb_t   t0,
	input  wire limb_t   m_prime,
	output limb_t        u
);

	limb_t             s_q, u_q;
	logic              phase;
	logic [1:0]        k;
	limb_t             a_op, b_op;
	logic [HALF_W-1:0] a_half, b_half;
	logic [LIMB_W-1:0] prod;
	limb_t             term;

	always_comb begin
		phase  = (ctrl.step >= 3'd3);
		k      = phase ? 2'(ctrl.step - 3'd3) : ctrl.step[1:0];
		a_op   = phase ? s_q : xb;
		b_op   = phase ? m_prime : y0;
		a_half = (k == 2'd2) ? a_op[LIMB_W-1:HALF_W] : a_op[HALF_W-1:0];
		b_half = (k == 2'd1) ? b_op[LIMB_W-1:HALF_W] : b_op[HALF_W-1:0];
		prod   = a_half * b_half;
		term   = (k == 2'd0) ? prod : {prod[HALF_W-1:0], {HALF_W{1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			if (!phase)
				s_q <= ((k == 2'd0) ? t0 : s_q) + term;
			else
				u_q <= ((k == 2'd0) ? '0 : u_q) + term;
		end
	end

	assign u = u_q;

endmodule
`default_nettype wire

[rtl/montgomery_modular_multiplier_core.sv]
// Montgomery multiplier, x*y*2^(-64*LIMBS) mod m, 64-bit limbs.
// operand channel: one request per limb pair (x_limb, y_limb), least
// significant first; last_limb on the final pair starts the multiply.
// Pairs beyond LIMBS are dropped; positions not loaded keep old limbs.
// result channel: LIMBS requests, least significant limb first,
// last_result on the top limb.
// wr_en/wr_idx/wr_data: indexes 0..LIMBS-1 modulus limbs, 6 m_prime.
// Write only while idle.
// Each limb position is a cell with its own 32x32 multiplier; the carry
// ripples cell to cell. Per round: u in the shared unit, MAC steps,
// a carry ripple through each position, then a shift down one limb.
// After the last round the modulus is subtracted position by position;
// results then leave one per cycle while result ready is high. Operand
// ready is low from the last pair until the top result limb is taken.
// A stalled result channel simply holds the current limb.
// Reset returns the sequencer to idle and the load index to zero and
// clears modulus and m_prime; operand registers are not reset.
`default_nettype none
module montgomery_modular_multiplier_core import mmm_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	mmm_in_if.sink                    operand,
	mmm_out_if.source                 result,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_idx,
	input  wire limb_t                wr_data
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_UCALC  = 7'b0000010,
		S_MAC    = 7'b0000100,
		S_RIPPLE = 7'b0001000,
		S_SHIFT  = 7'b0010000,
		S_SUB    = 7'b0100000,
		S_EMIT   = 7'b1000000
	} state_t;

	localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(LIMBS - 1);

	state_t           state_q;
	logic [2:0]       step_q;
	logic [IDX_W-1:0] round_q, pos_q;
	logic [CNT_W-1:0] load_idx_q;
	logic             tb_q;
	limb_t            m_prime_q;

	cell_ctrl_t         cc [LIMBS];
	logic [CARRY_W-1:0] carry [LIMBS];
	logic               borrow [LIMBS];
	limb_t              x_arr [LIMBS];
	limb_t              y_arr [LIMBS];
	limb_t              t_arr [LIMBS];
	limb_t              d_arr [LIMBS];

	u_ctrl_t          uc;
	limb_t            u, xb;
	logic [LIMB_W:0]  top_sum;
	logic             in_acc, out_acc, load_ok, sel;

	assign in_acc  = operand.valid & operand.ready;
	assign out_acc = result.valid & result.ready;
	assign load_ok = (load_idx_q < CNT_W'(LIMBS));
	assign xb      = x_arr[round_q];
	assign top_sum = (LIMB_W+1)'(carry[LIMBS-1]) + (LIMB_W+1)'(tb_q);
	assign sel     = tb_q | ~borrow[LIMBS-1];

	assign operand.ready      = (state_q == S_IDLE);
	assign result.valid       = (state_q == S_EMIT);
	assign result.result_limb = sel ? d_arr[0] : t_arr[0];
	assign result.last_result = (pos_q == LAST_POS);

	always_comb begin
		uc.en   = (state_q == S_UCALC);
		uc.step = step_q;
		for (int j = 0; j < LIMBS; j++) begin
			cc[j].clear     = in_acc & operand.last_limb;
			cc[j].load_we   = in_acc & load_ok &
			                  (load_idx_q[IDX_W-1:0] == IDX_W'(j));
			cc[j].cfg_we    = wr_en & (wr_idx == CFG_IDX_W'(j));
			cc[j].mac_en    = (state_q == S_MAC);
			cc[j].mac_init  = (step_q == 3'd0);
			cc[j].mac_step  = step_q;
			cc[j].ripple_en = (state_q == S_RIPPLE) & (pos_q == IDX_W'(j));
			cc[j].shift_en  = (state_q == S_SHIFT) | out_acc;
			cc[j].sub_en    = (state_q == S_SUB) & (pos_q == IDX_W'(j));
		end
	end

	for (genvar j = 0; j < LIMBS; j++) begin : g_cell
		logic [CARRY_W-1:0] c_in;
		logic               b_in;
		limb_t              t_nx, d_nx;
		if (j == 0) begin : g_first
			assign c_in = '0;
			assign b_in = 1'b0;
		end else begin : g_rest
			assign c_in = carry[j-1];
			assign b_in = borrow[j-1];
		end
		if (j == LIMBS - 1) begin : g_top
			assign t_nx = top_sum[LIMB_W-1:0];
			assign d_nx = '0;
		end else begin : g_mid
			assign t_nx = t_arr[j+1];
			assign d_nx = d_arr[j+1];
		end
		mmm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cc[j]),
			.x_in       (operand.x_limb),
			.y_in       (operand.y_limb),
			.cfg_data   (wr_data),
			.xb         (xb),
			.u          (u),
			.carry_in   (c_in),
			.borrow_in  (b_in),
			.t_next     (t_nx),
			.d_next     (d_nx),
			.carry_out  (carry[j]),
			.borrow_out (borrow[j]),
			.x_out      (x_arr[j]),
			.y_out      (y_arr[j]),
			.t_out      (t_arr[j]),
			.d_out      (d_arr[j])
		);
	end

	mmm_u_unit u_unit (
		.clk     (clk),
		.ctrl    (uc),
		.xb      (xb),
		.y0      (y_arr[0]),
		.t0      (t_arr[0]),
		.m_prime (m_prime_q),
		.u       (u)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_prime_q <= '0;
		else if (wr_en && wr_idx == CFG_M_PRIME)
			m_prime_q <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			step_q     <= '0;
			round_q    <= '0;
			pos_q      <= '0;
			load_idx_q <= '0;
			tb_q       <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (operand.last_limb) begin
							load_idx_q <= '0;
							tb_q       <= 1'b0;
							round_q    <= '0;
							step_q     <= '0;
							state_q    <= S_UCALC;
						end else if (load_ok)
							load_idx_q <= load_idx_q + CNT_W'(1);
					end
				end
				S_UCALC: begin
					if (step_q == 3'd5) begin
						step_q  <= '0;
						state_q <= S_MAC;
					end else
						step_q <= step_q + 3'd1;
				end
				S_MAC: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) begin
						pos_q   <= '0;
						state_q <= S_RIPPLE;
					end
				end
				S_RIPPLE: begin
					if (pos_q == LAST_POS)
						state_q <= S_SHIFT;
					else
						pos_q <= pos_q + IDX_W'(1);
				end
				S_SHIFT: begin
					tb_q   <= top_sum[LIMB_W];
					pos_q  <= '0;
					step_q <= '0;
					if (round_q == LAST_POS)
						state_q <= S_SUB;
					else begin
						round_q <= round_q + IDX_W'(1);
						state_q <= S_UCALC;
					end
				end
				S_SUB: begin
					if (pos_q == LAST_POS) begin
						pos_q   <= '0;
						state_q <= S_EMIT;
					end else
						pos_q <= pos_q + IDX_W'(1);
				end
				S_EMIT: begin
					if (out_acc) begin
						if (pos_q == LAST_POS) begin
							pos_q   <= '0;
							state_q <= S_IDLE;
						end else
							pos_q <= pos_q + IDX_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[dv/testbench.sv]
`default_nettype none
module testbench;
	import mmm_pkg::*;

	localparam int WIDE_W   = 128 * LIMBS + 8;
	localparam int OPER_W   = 64 * LIMBS;
	localparam int IDLE_GAP = 120;
	localparam int WD_LIMIT = 40000;

	class mont_scoreboard;
		limb_t       modulus [MAX_LIMBS];
		limb_t       m_prime;
		limb_t       x_store [LIMBS];
		limb_t       y_store [LIMBS];
		int unsigned load_idx;
		limb_t       limb_q [$];
		bit          last_q [$];
		int          errors;

		function void write_reg(int idx, limb_t v);
			if (idx < MAX_LIMBS)
				modulus[idx] = v;
			else if (idx == int'(CFG_M_PRIME))
				m_prime = v;
		endfunction

		function void note_request(limb_t x, limb_t y, bit last);
			logic [WIDE_W-1:0] acc;
			logic [OPER_W-1:0] res;
			logic [OPER_W-1:0] mv;
			limb_t             u;
			bit                carry_out;
			if (load_idx < LIMBS) begin
				x_store[load_idx] = x;
				y_store[load_idx] = y;
				load_idx++;
			end
			if (!last)
				return;
			load_idx = 0;
			acc = '0;
			for (int i = 0; i < LIMBS; i++) begin
				u = acc[64*i +: 64] + x_store[i] * y_store[0];
				u = u * m_prime;
				for (int j = 0; j < LIMBS; j++) begin
					acc = acc + ((WIDE_W'(x_store[i]) * WIDE_W'(y_store[j])) << (64 * (i + j)));
					acc = acc + ((WIDE_W'(u) * WIDE_W'(modulus[j])) << (64 * (i + j)));
				end
			end
			carry_out = |acc[WIDE_W-1:128*LIMBS];
			res = acc[128*LIMBS-1:OPER_W];
			for (int k = 0; k < LIMBS; k++)
				mv[64*k +: 64] = modulus[k];
			if (carry_out || res >= mv)
				res = res - mv;
			for (int k = 0; k < LIMBS; k++) begin
				limb_q.push_back(res[64*k +: 64]);
				last_q.push_back(k == LIMBS - 1);
			end
		endfunction

		function void check_result(limb_t r, bit l);
			limb_t el;
			bit    ell;
			if (limb_q.size() == 0) begin
				$error("unexpected result limb %h", r);
				errors++;
				return;
			end
			el = limb_q.pop_front();
			ell = last_q.pop_front();
			if (r !== el) begin
				$error("result_limb expected %h actual %h", el, r);
				errors++;
			end
			if (l !== ell) begin
				$error("last_result expected %0d actual %0d", ell, l);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_idx;
	limb_t                wr_data;
	int                   send_idle;
	int                   recv_idle;
	int                   quiet_cycles;
	limb_t                cur_mod [MAX_LIMBS];
	mont_scoreboard       sb;

	mmm_in_if  op_ch ();
	mmm_out_if res_ch ();

	montgomery_modular_multiplier_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (op_ch),
		.result  (res_ch),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		res_ch.ready = ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (op_ch.valid && op_ch.ready)
				sb.note_request(op_ch.x_limb, op_ch.y_limb, op_ch.last_limb);
			if (res_ch.valid && res_ch.ready)
				sb.check_result(res_ch.result_limb, res_ch.last_result);
			if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready) || wr_en)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WD_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	function automatic limb_t rand_limb();
		return {$urandom, $urandom};
	endfunction

	function automatic limb_t pick_limb();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return cur_mod[$urandom_range(LIMBS - 1)];
			default: return rand_limb();
		endcase
	endfunction

	function automatic limb_t neg_inverse(limb_t m0);
		limb_t inv;
		inv = m0;
		repeat (6) inv = inv * (64'd2 - m0 * inv);
		return -inv;
	endfunction

	task automatic write_reg(int idx, limb_t v);
		@(negedge clk);
		wr_en = 1'b1;
		wr_idx = CFG_IDX_W'(idx);
		wr_data = v;
		sb.write_reg(idx, v);
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task automatic load_modulus(limb_t mp);
		for (int i = 0; i < MAX_LIMBS; i++)
			write_reg(i, cur_mod[i]);
		write_reg(int'(CFG_M_PRIME), mp);
	endtask

	task automatic random_modulus();
		for (int i = 0; i < MAX_LIMBS; i++)
			cur_mod[i] = rand_limb();
		cur_mod[0][0] = 1'b1;
		if ($urandom_range(1))
			cur_mod[LIMBS-1][63] = 1'b1;
		load_modulus(neg_inverse(cur_mod[0]));
	endtask

	task automatic drain();
		while (sb.limb_q.size() != 0)
			@(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic send_pair(limb_t x, limb_t y, bit last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			op_ch.valid = 1'b0;
			@(negedge clk);
		end
		op_ch.valid = 1'b1;
		op_ch.x_limb = x;
		op_ch.y_limb = y;
		op_ch.last_limb = last;
		@(posedge clk);
		while (!op_ch.ready)
			@(posedge clk);
		@(negedge clk);
		op_ch.valid = 1'b0;
	endtask

	task automatic send_op(int n, int mode);
		limb_t x;
		limb_t y;
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: begin x = '0; y = '0; end
				1: begin x = '1; y = '1; end
				2: begin x = cur_mod[i % LIMBS]; y = '1; end
				default: begin x = pick_limb(); y = pick_limb(); end
			endcase
			send_pair(x, y, i == n - 1);
		end
	endtask

	task automatic random_ops(int items);
		int sent;
		int n;
		sent = 0;
		while (sent < items) begin
			case ($urandom_range(9))
				0: n = $urandom_range(1, LIMBS - 1);
				1: n = $urandom_range(LIMBS + 1, LIMBS + 3);
				default: n = LIMBS;
			endcase
			send_op(n, 3);
			sent += n;
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_idx = '0;
		wr_data = '0;
		op_ch.valid = 1'b0;
		op_ch.x_limb = '0;
		op_ch.y_limb = '0;
		op_ch.last_limb = 1'b0;
		res_ch.ready = 1'b0;
		send_idle = 0;
		recv_idle = 0;
		quiet_cycles = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all-ones modulus
		for (int i = 0; i < MAX_LIMBS; i++)
			cur_mod[i] = '1;
		load_modulus(neg_inverse(cur_mod[0]));
		send_op(LIMBS, 0);
		send_op(LIMBS, 1);
		send_op(LIMBS, 2);
		send_op(1, 1);
		send_op(LIMBS + 2, 3);
		drain();

		// modulus of one
		for (int i = 0; i < MAX_LIMBS; i++)
			cur_mod[i] = '0;
		cur_mod[0] = 64'd1;
		load_modulus(neg_inverse(cur_mod[0]));
		send_op(LIMBS, 1);
		send_op(2, 3);
		drain();

		// even modulus, bad m_prime, zero m_prime
		random_modulus();
		cur_mod[0][0] = 1'b0;
		load_modulus(rand_limb());
		send_op(LIMBS, 1);
		send_op(LIMBS, 3);
		drain();
		load_modulus('0);
		send_op(LIMBS, 3);
		drain();

		send_idle = 28;
		recv_idle = 85;
		random_modulus();
		random_ops(75);
		drain();

		send_idle = 85;
		recv_idle = 28;
		random_modulus();
		random_ops(75);
		drain();

		send_idle = 0;
		recv_idle = 0;
		random_modulus();
		random_ops(75);
		drain();

		if (sb.errors == 0 && sb.limb_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
